### src/wto_pkg.sv
// shared types and constants for the wedge/triangle overlap test
// no dependencies; imported by wedge_triangle_overlap_test_core
package wto_pkg;

	// signed Q8.8 coordinate, its difference and its products
	typedef logic signed [15:0] coord_t;
	typedef logic signed [16:0] diff_t;
	typedef logic signed [33:0] prod_t;
	typedef logic signed [34:0] cross_t;

	// configuration register map, word index
	typedef enum logic [2:0] {
		REG_APEX_X      = 3'd0,
		REG_APEX_Y      = 3'd1,
		REG_LEFT_RAY_X  = 3'd2,
		REG_LEFT_RAY_Y  = 3'd3,
		REG_RIGHT_RAY_X = 3'd4,
		REG_RIGHT_RAY_Y = 3'd5
	} reg_idx_t;

	localparam int unsigned ADDR_W = 5;

	// reset values of the wedge registers
	localparam coord_t APEX_X_RST      = 16'sd0;
	localparam coord_t APEX_Y_RST      = 16'sd0;
	localparam coord_t LEFT_RAY_X_RST  = 16'sd0;
	localparam coord_t LEFT_RAY_Y_RST  = 16'sd256;
	localparam coord_t RIGHT_RAY_X_RST = 16'sd0;
	localparam coord_t RIGHT_RAY_Y_RST = 16'sd256;

	// vertex class bits
	typedef logic [1:0] cls_t;
	localparam cls_t CLS_RIGHT = 2'h1;
	localparam cls_t CLS_LEFT  = 2'h2;
	localparam cls_t CLS_BOTH  = 2'h3;

	// sign extend a coordinate and subtract, exact in 17 bits
	function automatic diff_t coord_sub(coord_t a, coord_t b);
		diff_t r;
		r = diff_t'(a) - diff_t'(b);
		return r;
	endfunction

	// exact cross product from two products
	function automatic cross_t prod_sub(prod_t a, prod_t b);
		cross_t r;
		r = cross_t'(a) - cross_t'(b);
		return r;
	endfunction

endpackage

### src/wedge_triangle_overlap_test_core.sv
// wedge/triangle overlap test: four stage pipeline plus apb register block
// depends on wto_pkg
//
// done follows an accepted start through the valid bits vld_s1 to vld_s4
// throughput: one item per cycle; busy is tied low, the receiver cannot stall
// the pipeline stages are differences, products, cross signs, combine/output
// reset clears the valid bits and loads the wedge registers with their defaults
module wedge_triangle_overlap_test_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// apb configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wto_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// command side
	input  logic                         start,
	output logic                         busy,
	input  wto_pkg::coord_t              vert0_x,
	input  wto_pkg::coord_t              vert0_y,
	input  wto_pkg::coord_t              vert1_x,
	input  wto_pkg::coord_t              vert1_y,
	input  wto_pkg::coord_t              vert2_x,
	input  wto_pkg::coord_t              vert2_y,
	// result side
	output logic                         done,
	output logic                         overlaps
);
	import wto_pkg::*;

	coord_t apex_x_q, apex_y_q, left_ray_x_q, left_ray_y_q, right_ray_x_q, right_ray_y_q;
	reg_idx_t wr_idx;
	logic     wr_en;

	coord_t vx [3];
	coord_t vy [3];

	// stage 1: differences
	logic  vld_s1;
	diff_t arx_s1, ary_s1, alx_s1, aly_s1;
	diff_t dax_s1 [3];
	diff_t day_s1 [3];
	diff_t dlx_s1 [3];
	diff_t dly_s1 [3];
	diff_t ex_s1  [3];
	diff_t ey_s1  [3];
	diff_t eax_s1 [3];
	diff_t eay_s1 [3];

	// stage 2: products
	logic  vld_s2;
	prod_t pra_s2 [3];
	prod_t prb_s2 [3];
	prod_t pla_s2 [3];
	prod_t plb_s2 [3];
	prod_t pea_s2 [3];
	prod_t peb_s2 [3];

	// stage 3: classes and edge turn signs
	logic  vld_s3;
	cls_t  cls_s3 [3];
	logic  epos_s3 [3];
	logic  eneg_s3 [3];

	// stage 4: result
	logic  vld_s4;
	logic  hit_s4;

	logic  hit_c;

	// apb access, always ready
	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel & penable & pwrite & pready;
	assign wr_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	// register writes; indexes beyond the map are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apex_x_q      <= APEX_X_RST;
			apex_y_q      <= APEX_Y_RST;
			left_ray_x_q  <= LEFT_RAY_X_RST;
			left_ray_y_q  <= LEFT_RAY_Y_RST;
			right_ray_x_q <= RIGHT_RAY_X_RST;
			right_ray_y_q <= RIGHT_RAY_Y_RST;
		end else if (wr_en) begin
			case (wr_idx)
				REG_APEX_X:      apex_x_q      <= pwdata[15:0];
				REG_APEX_Y:      apex_y_q      <= pwdata[15:0];
				REG_LEFT_RAY_X:  left_ray_x_q  <= pwdata[15:0];
				REG_LEFT_RAY_Y:  left_ray_y_q  <= pwdata[15:0];
				REG_RIGHT_RAY_X: right_ray_x_q <= pwdata[15:0];
				REG_RIGHT_RAY_Y: right_ray_y_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (wr_idx)
			REG_APEX_X:      prdata = {16'h0, apex_x_q};
			REG_APEX_Y:      prdata = {16'h0, apex_y_q};
			REG_LEFT_RAY_X:  prdata = {16'h0, left_ray_x_q};
			REG_LEFT_RAY_Y:  prdata = {16'h0, left_ray_y_q};
			REG_RIGHT_RAY_X: prdata = {16'h0, right_ray_x_q};
			REG_RIGHT_RAY_Y: prdata = {16'h0, right_ray_y_q};
			default:         prdata = 32'h0;
		endcase
	end

	assign vx[0] = vert0_x;
	assign vy[0] = vert0_y;
	assign vx[1] = vert1_x;
	assign vy[1] = vert1_y;
	assign vx[2] = vert2_x;
	assign vy[2] = vert2_y;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1: coordinate differences against the apex, left ray point and edges
	always_ff @(posedge clk) begin
		arx_s1 <= coord_sub(right_ray_x_q, apex_x_q);
		ary_s1 <= coord_sub(right_ray_y_q, apex_y_q);
		alx_s1 <= coord_sub(apex_x_q, left_ray_x_q);
		aly_s1 <= coord_sub(apex_y_q, left_ray_y_q);
		for (int i = 0; i < 3; i++) begin
			dax_s1[i] <= coord_sub(vx[i], apex_x_q);
			day_s1[i] <= coord_sub(vy[i], apex_y_q);
			dlx_s1[i] <= coord_sub(vx[i], left_ray_x_q);
			dly_s1[i] <= coord_sub(vy[i], left_ray_y_q);
			ex_s1[i]  <= coord_sub(vx[(i + 1) % 3], vx[i]);
			ey_s1[i]  <= coord_sub(vy[(i + 1) % 3], vy[i]);
			eax_s1[i] <= coord_sub(apex_x_q, vx[i]);
			eay_s1[i] <= coord_sub(apex_y_q, vy[i]);
		end
	end

	// stage 2: 17x17 signed products
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pra_s2[i] <= prod_t'(arx_s1) * prod_t'(day_s1[i]);
			prb_s2[i] <= prod_t'(ary_s1) * prod_t'(dax_s1[i]);
			pla_s2[i] <= prod_t'(alx_s1) * prod_t'(dly_s1[i]);
			plb_s2[i] <= prod_t'(aly_s1) * prod_t'(dlx_s1[i]);
			pea_s2[i] <= prod_t'(ex_s1[i]) * prod_t'(eay_s1[i]);
			peb_s2[i] <= prod_t'(ey_s1[i]) * prod_t'(eax_s1[i]);
		end
	end

	// stage 3: signs of the cross products, zero is neither turn
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			cross_t cr, cl, ce;
			cr = prod_sub(pra_s2[i], prb_s2[i]);
			cl = prod_sub(pla_s2[i], plb_s2[i]);
			ce = prod_sub(pea_s2[i], peb_s2[i]);
			cls_s3[i]  <= {(cl > 0), (cr > 0)};
			epos_s3[i] <= (ce > 0);
			eneg_s3[i] <= ce[34];
		end
	end

	// combine: vertex inside, or a straddling edge passing the apex on its side
	always_comb begin
		hit_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (cls_s3[i] == CLS_BOTH)
				hit_c = 1'b1;
			if ((cls_s3[i] | cls_s3[(i + 1) % 3]) == CLS_BOTH) begin
				if (cls_s3[i] == CLS_RIGHT && eneg_s3[i])
					hit_c = 1'b1;
				if (cls_s3[i] == CLS_LEFT && epos_s3[i])
					hit_c = 1'b1;
			end
		end
	end

	// stage 4: output register
	always_ff @(posedge clk) begin
		hit_s4 <= hit_c;
	end

	assign done     = vld_s4;
	assign overlaps = hit_s4;

endmodule

### tb/sv/wedge_triangle_overlap_test_core_test.sv
// self-checking bench for the wedge/triangle overlap core: directed and random triangles
// under several wedge settings, each overlap flag checked against an in-bench predictor
// depends on wto_pkg and wedge_triangle_overlap_test_core
module wedge_triangle_overlap_test_core_test;
	import wto_pkg::*;

	localparam int unsigned NUM_WEDGE_REGS = REG_RIGHT_RAY_Y + 1;
	localparam int unsigned PIPE_LATENCY   = 4;
	localparam int unsigned QUIET_LIMIT    = 2000;
	localparam int unsigned NUM_SETTINGS   = 8;
	localparam int unsigned ITEMS_PER_SET  = 210;

	typedef struct packed {
		coord_t x0, y0, x1, y1, x2, y2;
	} triangle_t;

	// holds the wedge registers as written and the overlap flags still owed by the core
	class wedge_hit_tracker;
		coord_t      wedge [NUM_WEDGE_REGS];
		bit          expected_hits [$];
		int unsigned mismatches;

		function new();
			wedge[REG_APEX_X]      = APEX_X_RST;
			wedge[REG_APEX_Y]      = APEX_Y_RST;
			wedge[REG_LEFT_RAY_X]  = LEFT_RAY_X_RST;
			wedge[REG_LEFT_RAY_Y]  = LEFT_RAY_Y_RST;
			wedge[REG_RIGHT_RAY_X] = RIGHT_RAY_X_RST;
			wedge[REG_RIGHT_RAY_Y] = RIGHT_RAY_Y_RST;
			mismatches = 0;
		endfunction

		// unmapped word addresses are dropped, upper data bits are discarded
		function void load_register(logic [ADDR_W-1:0] addr, logic [31:0] data);
			int unsigned idx;
			idx = addr >> 2;
			if (idx < NUM_WEDGE_REGS)
				wedge[idx] = data[15:0];
		endfunction

		static function longint widen(coord_t v);
			return longint'(v);
		endfunction

		// sign of the turn p1->p2->p3: +1 left, -1 right, 0 collinear
		static function int orient(longint x1, longint y1, longint x2, longint y2,
			longint x3, longint y3);
			longint c;
			c = (x2 - x1) * (y3 - y1) - (y2 - y1) * (x3 - x1);
			return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
		endfunction

		function bit predict_overlap(triangle_t t);
			longint ax, ay, lx, ly, rx, ry;
			longint vx [3];
			longint vy [3];
			cls_t   cls [3];
			bit     hit;
			int     j;
			ax = widen(wedge[REG_APEX_X]);
			ay = widen(wedge[REG_APEX_Y]);
			lx = widen(wedge[REG_LEFT_RAY_X]);
			ly = widen(wedge[REG_LEFT_RAY_Y]);
			rx = widen(wedge[REG_RIGHT_RAY_X]);
			ry = widen(wedge[REG_RIGHT_RAY_Y]);
			vx[0] = widen(t.x0); vy[0] = widen(t.y0);
			vx[1] = widen(t.x1); vy[1] = widen(t.y1);
			vx[2] = widen(t.x2); vy[2] = widen(t.y2);
			hit = 0;
			// classify each vertex against both boundary lines
			for (int i = 0; i < 3; i++) begin
				cls[i] = '0;
				if (orient(ax, ay, rx, ry, vx[i], vy[i]) > 0)
					cls[i] |= CLS_RIGHT;
				if (orient(lx, ly, ax, ay, vx[i], vy[i]) > 0)
					cls[i] |= CLS_LEFT;
				if (cls[i] == CLS_BOTH)
					hit = 1;
			end
			// edges whose ends fall on opposite sides must pass the apex correctly
			for (int i = 0; i < 3 && !hit; i++) begin
				j = (i + 1) % 3;
				if ((cls[i] | cls[j]) == CLS_BOTH) begin
					if (cls[i] == CLS_RIGHT) begin
						if (orient(vx[i], vy[i], vx[j], vy[j], ax, ay) < 0)
							hit = 1;
					end else if (cls[i] == CLS_LEFT) begin
						if (orient(vx[i], vy[i], vx[j], vy[j], ax, ay) > 0)
							hit = 1;
					end
				end
			end
			return hit;
		endfunction

		function void note_triangle(triangle_t t);
			expected_hits.push_back(predict_overlap(t));
		endfunction

		function void check_overlap(logic got);
			bit want;
			if (expected_hits.size() == 0) begin
				$error("overlaps: no item waiting, expected none, actual %0b", got);
				mismatches++;
			end else begin
				want = expected_hits.pop_front();
				if (got !== want) begin
					$error("overlaps: expected %0b, actual %0b", want, got);
					mismatches++;
				end
			end
		endfunction

		function int unsigned pending();
			return expected_hits.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata, prdata;
	logic              pready;
	logic              start, busy;
	coord_t            vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y;
	logic              done, overlaps;

	wedge_hit_tracker board;
	int unsigned      quiet_cycles = 0;

	wedge_triangle_overlap_test_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.start    (start),
		.busy     (busy),
		.vert0_x  (vert0_x),
		.vert0_y  (vert0_y),
		.vert1_x  (vert1_x),
		.vert1_y  (vert1_y),
		.vert2_x  (vert2_x),
		.vert2_y  (vert2_y),
		.done     (done),
		.overlaps (overlaps)
	);

	always #6 clk = ~clk;

	// observe accepted items, register writes and results on every rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_triangle('{vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y});
			if (psel && penable && pwrite && pready)
				board.load_register(paddr, pwdata);
			if (done)
				board.check_overlap(overlaps);
		end
		if ((start && !busy) || (psel && penable && pready) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// watchdog on cycles with nothing accepted and no result returned
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("wedge_triangle_overlap_test_core_test: FAIL");
		$finish;
	end

	function automatic triangle_t make_tri(int a, int b, int c, int d, int e, int f);
		triangle_t t;
		t = '{coord_t'(a), coord_t'(b), coord_t'(c), coord_t'(d), coord_t'(e), coord_t'(f)};
		return t;
	endfunction

	// directed triangles: range extremes, collinear vertices, straddling edges
	function automatic triangle_t directed_triangle(int unsigned k);
		case (k)
			0:  return make_tri(0, 0, 0, 0, 0, 0);
			1:  return make_tri(32767, 32767, 32767, 32767, 32767, 32767);
			2:  return make_tri(-32768, -32768, -32768, -32768, -32768, -32768);
			3:  return make_tri(-32768, 32767, 32767, -32768, 32767, 32767);
			4:  return make_tri(32767, -32768, -32768, 32767, -32768, -32768);
			5:  return make_tri(-256, 0, 256, 0, 0, 256);
			6:  return make_tri(-256, -256, 256, -256, 0, 256);
			7:  return make_tri(256, -256, -256, -256, 0, 256);
			8:  return make_tri(-256, 256, 256, 256, 0, 512);
			9:  return make_tri(256, 256, -256, 256, 0, 512);
			10: return make_tri(0, 512, 0, -512, 256, 0);
			11: return make_tri(-256, 5, -256, 5, 300, -7);
			12: return make_tri(-1, 100, 1, 100, -1, 100);
			default: return make_tri(1, -1, -1, 1, 1, 1);
		endcase
	endfunction

	// vertex near the wedge's own points, rich in collinear and coincident cases
	function automatic void anchor_point(output coord_t px, output coord_t py);
		coord_t ax, ay, lx, ly, rx, ry;
		ax = board.wedge[REG_APEX_X];
		ay = board.wedge[REG_APEX_Y];
		lx = board.wedge[REG_LEFT_RAY_X];
		ly = board.wedge[REG_LEFT_RAY_Y];
		rx = board.wedge[REG_RIGHT_RAY_X];
		ry = board.wedge[REG_RIGHT_RAY_Y];
		case ($urandom_range(5))
			0: begin px = ax; py = ay; end
			1: begin px = lx; py = ly; end
			2: begin px = rx; py = ry; end
			3: begin px = coord_t'(2 * rx - ax); py = coord_t'(2 * ry - ay); end
			4: begin px = coord_t'(2 * ax - lx); py = coord_t'(2 * ay - ly); end
			default: begin
				px = coord_t'(ax + int'($urandom_range(8)) - 4);
				py = coord_t'(ay + int'($urandom_range(8)) - 4);
			end
		endcase
	endfunction

	function automatic triangle_t random_triangle();
		coord_t      px [3];
		coord_t      py [3];
		int unsigned mode;
		mode = $urandom_range(99);
		for (int i = 0; i < 3; i++) begin
			if (mode < 40) begin
				px[i] = coord_t'($urandom);
				py[i] = coord_t'($urandom);
			end else if (mode < 70) begin
				px[i] = coord_t'(board.wedge[REG_APEX_X] + int'($urandom_range(1200)) - 600);
				py[i] = coord_t'(board.wedge[REG_APEX_Y] + int'($urandom_range(1200)) - 600);
			end else if (mode < 85) begin
				anchor_point(px[i], py[i]);
			end else if (i > 0 && $urandom_range(1)) begin
				px[i] = px[i-1];
				py[i] = py[i-1];
			end else begin
				px[i] = coord_t'($urandom);
				py[i] = coord_t'($urandom);
			end
		end
		return '{px[0], py[0], px[1], py[1], px[2], py[2]};
	endfunction

	task automatic drive_triangle(triangle_t t);
		start   <= 1'b1;
		vert0_x <= t.x0;
		vert0_y <= t.y0;
		vert1_x <= t.x1;
		vert1_y <= t.y1;
		vert2_x <= t.x2;
		vert2_y <= t.y2;
		do @(posedge clk); while (busy);
	endtask

	// each cycle idles with the given chance in a hundred
	task automatic sender_gap(int unsigned pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// hold off until every owed result is back, then let the pipe empty
	task automatic drain_pipe();
		start <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// setup then access phase; psel is left high for a following write
	task automatic apb_write(int unsigned index, logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(index << 2);
		pwdata  <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic program_wedge(coord_t ax, coord_t ay, coord_t lx, coord_t ly,
		coord_t rx, coord_t ry);
		drain_pipe();
		apb_write(REG_APEX_X, ax);
		apb_write(REG_APEX_Y, ay);
		apb_write(REG_LEFT_RAY_X, lx);
		apb_write(REG_LEFT_RAY_Y, ly);
		apb_write(REG_RIGHT_RAY_X, rx);
		apb_write(REG_RIGHT_RAY_Y, ry);
		// unmapped word, must leave the wedge alone
		apb_write(NUM_WEDGE_REGS + $urandom_range(1), 16'($urandom));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// pick one of the wedge settings, extremes and degenerate rays among them
	task automatic select_wedge(int unsigned k);
		coord_t ax, ay;
		ax = coord_t'($urandom);
		ay = coord_t'($urandom);
		case (k)
			0: program_wedge(coord_t'(0), coord_t'(0), coord_t'(-512), coord_t'(512),
				coord_t'(512), coord_t'(512));
			1: program_wedge(coord_t'(-32768), coord_t'(-32768), coord_t'(-32768),
				coord_t'(32767), coord_t'(32767), coord_t'(-32768));
			2: program_wedge(coord_t'(32767), coord_t'(32767), coord_t'(32767),
				coord_t'(-32768), coord_t'(-32768), coord_t'(32767));
			3: program_wedge(ax, ay, ax, ay, coord_t'($urandom), coord_t'($urandom));
			4: program_wedge(ax, ay, coord_t'($urandom), coord_t'($urandom), ax, ay);
			5: program_wedge(ax, ay, coord_t'(ax + int'($urandom_range(16)) - 8),
				coord_t'(ay + int'($urandom_range(16)) - 8),
				coord_t'(ax + int'($urandom_range(16)) - 8),
				coord_t'(ay + int'($urandom_range(16)) - 8));
			default: program_wedge(ax, ay, coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), coord_t'($urandom));
		endcase
	endtask

	initial begin
		int unsigned gap_pct;
		board   = new();
		arst_n  <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		start   <= 1'b0;
		vert0_x <= '0;
		vert0_y <= '0;
		vert1_x <= '0;
		vert1_y <= '0;
		vert2_x <= '0;
		vert2_y <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items against the reset wedge
		for (int unsigned k = 0; k < 14; k++)
			drive_triangle(directed_triangle(k));

		// random items per wedge setting, sender idling light, then heavier, then none
		for (int unsigned s = 0; s < NUM_SETTINGS; s++) begin
			gap_pct = (s < 3) ? 34 : ((s < 6) ? 51 : 0);
			select_wedge(s);
			for (int unsigned n = 0; n < ITEMS_PER_SET; n++) begin
				if (n == ITEMS_PER_SET / 2)
					drain_pipe();
				drive_triangle(random_triangle());
				sender_gap(gap_pct);
			end
		end

		drain_pipe();
		if (board.mismatches == 0)
			$display("wedge_triangle_overlap_test_core_test: PASS");
		else
			$display("wedge_triangle_overlap_test_core_test: FAIL");
		$finish;
	end

endmodule
